>>> hw/rtl/nps_pkg.sv
// Package for the nearest point search table: field widths, codes and types.
// Shared by the channel interfaces and the core; depends on nothing.
package nps_pkg;

   localparam int unsigned DEPTH_DEFAULT    = 1024;
   localparam int unsigned MAX_DIMS_DEFAULT = 6;

   localparam int unsigned NUM_COORDS = 6;
   localparam int unsigned COORD_W    = 16;
   localparam int unsigned FUNC_W     = 2;
   localparam int unsigned INDEX_W    = 10;
   localparam int unsigned DIST_W     = 37;
   localparam int unsigned COUNT_W    = 11;
   localparam int unsigned DIMS_W     = 3;
   localparam int unsigned SQ_W       = 32;

   typedef logic [FUNC_W-1:0]         func_type;
   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic [INDEX_W-1:0]        index_type;
   typedef logic [DIST_W-1:0]         dist_type;
   typedef logic [COUNT_W-1:0]        count_type;
   typedef logic [DIMS_W-1:0]         dims_type;
   typedef logic [SQ_W-1:0]           sq_type;

   localparam func_type FUNC_INSERT = 2'd0;
   localparam func_type FUNC_CLEAR  = 2'd1;
   localparam func_type FUNC_QUERY  = 2'd2;

   localparam dims_type DIMS_RESET = 3'd6;

   typedef enum logic [1:0] {
      OUTCOME_OK      = 2'd0,
      OUTCOME_FULL    = 2'd1,
      OUTCOME_EMPTY   = 2'd2,
      OUTCOME_CLEARED = 2'd3
   } outcome_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FLUSH,
      ST_EMIT
   } state_type;

endpackage

>>> hw/rtl/nps_req_if.sv
// Request channel of the nearest point search table: valid/ready plus payload.
// Depends on nps_pkg.
interface nps_req_if;
   import nps_pkg::*;

   logic      valid;
   logic      ready;
   func_type  func;
   coord_type coord_0;
   coord_type coord_1;
   coord_type coord_2;
   coord_type coord_3;
   coord_type coord_4;
   coord_type coord_5;

   modport source (
      output valid, func, coord_0, coord_1, coord_2, coord_3, coord_4, coord_5,
      input  ready
   );

   modport sink (
      input  valid, func, coord_0, coord_1, coord_2, coord_3, coord_4, coord_5,
      output ready
   );
endinterface

>>> hw/rtl/nps_rsp_if.sv
// Response channel of the nearest point search table: valid/ready plus payload.
// Depends on nps_pkg.
interface nps_rsp_if;
   import nps_pkg::*;

   logic        valid;
   logic        ready;
   index_type   point_index;
   outcome_type outcome;
   dist_type    best_dist_sq;
   count_type   point_count;

   modport source (
      output valid, point_index, outcome, best_dist_sq, point_count,
      input  ready
   );

   modport sink (
      input  valid, point_index, outcome, best_dist_sq, point_count,
      output ready
   );
endinterface

>>> hw/rtl/nearest_point_search_table_core.sv
// Nearest point search table: point memory, scan sequencer and distance pipeline.
// Depends on nps_pkg, nps_req_if and nps_rsp_if.
//
// Usage:
//   req_chan carries one request: func (insert, clear, query) and six signed
//   Q4.12 coordinates. rsp_chan returns exactly one response per request.
//   csr_wr_en/csr_wr_data set dims_in_use, the number of leading coordinates
//   used in the distance; write it only while the block is idle.
//   Insert, clear and unused func codes go from accept straight to the emit
//   state, which loads the output register once it is free. For a query, the
//   sequencer reads one stored point per cycle from the single read port of
//   the point memory and feeds a 3-stage distance pipeline (read, square,
//   sum) whose output is compared against the running best.
//   The block takes one request at a time; req_chan.ready is high only when
//   the sequencer is idle. The response sits in an output register, so a new
//   request is taken while the previous response still waits; a finished
//   result then holds until the receiver drains the output register.
//   Reset empties the table (count to zero) and sets dims_in_use to 6; the
//   point memory is not cleared, since only entries below the count are read.
module nearest_point_search_table_core #(
   parameter int unsigned DEPTH    = nps_pkg::DEPTH_DEFAULT,
   parameter int unsigned MAX_DIMS = nps_pkg::MAX_DIMS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   nps_req_if.sink              req_chan,
   nps_rsp_if.source            rsp_chan,
   input  logic                 csr_wr_en,
   input  nps_pkg::dims_type    csr_wr_data
);
   import nps_pkg::*;

   localparam int unsigned IDX_W   = $clog2(DEPTH);
   localparam int unsigned CNT_W   = $clog2(DEPTH + 1);
   localparam int unsigned ENTRY_W = MAX_DIMS * COORD_W;

   // point memory
   logic [ENTRY_W-1:0] mem [DEPTH];
   logic               mem_we;
   logic [ENTRY_W-1:0] mem_wr_data;
   logic               issue;

   // control and result registers
   state_type   state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] scan_ff, scan_in;
   logic        best_valid_ff, best_valid_in;
   logic [IDX_W-1:0] res_index_ff, res_index_in;
   outcome_type res_outcome_ff, res_outcome_in;
   dist_type    res_dist_ff, res_dist_in;
   logic [CNT_W-1:0] res_count_ff, res_count_in;
   coord_type   q_ff [MAX_DIMS];
   coord_type   q_in [MAX_DIMS];
   dims_type    dims_ff;

   logic        rsp_valid_ff, rsp_valid_in;
   index_type   rsp_index_ff, rsp_index_in;
   outcome_type rsp_outcome_ff, rsp_outcome_in;
   dist_type    rsp_dist_ff, rsp_dist_in;
   count_type   rsp_count_ff, rsp_count_in;

   // distance pipeline
   logic               v1_ff, v2_ff, v3_ff;
   logic [IDX_W-1:0]   idx1_ff, idx2_ff, idx3_ff;
   logic [ENTRY_W-1:0] rd_data_ff;
   sq_type             sq_in [MAX_DIMS];
   sq_type             sq_ff [MAX_DIMS];
   dist_type           sum_in;
   dist_type           dist_ff;

   coord_type          coord_arr [NUM_COORDS];
   dims_type           dims_eff;
   logic [CNT_W-1:0]   count_less;
   logic [IDX_W-1:0]   last_idx;
   logic               table_full;
   logic               rsp_free;

   assign coord_arr[0] = req_chan.coord_0;
   assign coord_arr[1] = req_chan.coord_1;
   assign coord_arr[2] = req_chan.coord_2;
   assign coord_arr[3] = req_chan.coord_3;
   assign coord_arr[4] = req_chan.coord_4;
   assign coord_arr[5] = req_chan.coord_5;

   always_comb begin
      for (int k = 0; k < MAX_DIMS; k++) begin
         mem_wr_data[k*COORD_W +: COORD_W] = coord_arr[k];
      end
   end

   // saturate dims_in_use to 1..MAX_DIMS
   always_comb begin
      if (dims_ff == '0) begin
         dims_eff = dims_type'(1);
      end else if (dims_ff > dims_type'(MAX_DIMS)) begin
         dims_eff = dims_type'(MAX_DIMS);
      end else begin
         dims_eff = dims_ff;
      end
   end

   assign count_less = count_ff - CNT_W'(1);
   assign last_idx   = count_less[IDX_W-1:0];
   assign table_full = (count_ff == CNT_W'(DEPTH));
   assign rsp_free   = !rsp_valid_ff || rsp_chan.ready;

   assign req_chan.ready        = (state_ff == ST_IDLE);
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.point_index  = rsp_index_ff;
   assign rsp_chan.outcome      = rsp_outcome_ff;
   assign rsp_chan.best_dist_sq = rsp_dist_ff;
   assign rsp_chan.point_count  = rsp_count_ff;

   // square stage: one difference and square per dimension
   always_comb begin
      logic signed [COORD_W:0]     diff;
      logic signed [2*COORD_W+1:0] prod;
      for (int k = 0; k < MAX_DIMS; k++) begin
         diff = $signed({rd_data_ff[k*COORD_W + COORD_W - 1],
                         rd_data_ff[k*COORD_W +: COORD_W]})
              - $signed({q_ff[k][COORD_W-1], q_ff[k]});
         prod = diff * diff;
         if (k < int'(dims_eff)) begin
            sq_in[k] = prod[SQ_W-1:0];
         end else begin
            sq_in[k] = '0;
         end
      end
   end

   always_comb begin
      sum_in = '0;
      for (int k = 0; k < MAX_DIMS; k++) begin
         sum_in = sum_in + DIST_W'(sq_ff[k]);
      end
   end

   // sequencer: next state, bookkeeping and result staging
   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      scan_in        = scan_ff;
      best_valid_in  = best_valid_ff;
      res_index_in   = res_index_ff;
      res_outcome_in = res_outcome_ff;
      res_dist_in    = res_dist_ff;
      res_count_in   = res_count_ff;
      q_in           = q_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      rsp_index_in   = rsp_index_ff;
      rsp_outcome_in = rsp_outcome_ff;
      rsp_dist_in    = rsp_dist_ff;
      rsp_count_in   = rsp_count_ff;
      mem_we         = 1'b0;
      issue          = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               for (int k = 0; k < MAX_DIMS; k++) begin
                  q_in[k] = coord_arr[k];
               end
               res_index_in   = '0;
               res_outcome_in = OUTCOME_OK;
               res_dist_in    = '0;
               res_count_in   = count_ff;
               state_in       = ST_EMIT;
               case (req_chan.func)
                  FUNC_INSERT: begin
                     if (table_full) begin
                        res_outcome_in = OUTCOME_FULL;
                     end else begin
                        mem_we       = 1'b1;
                        res_index_in = count_ff[IDX_W-1:0];
                        count_in     = count_ff + CNT_W'(1);
                        res_count_in = count_ff + CNT_W'(1);
                     end
                  end
                  FUNC_CLEAR: begin
                     count_in       = '0;
                     res_count_in   = '0;
                     res_outcome_in = OUTCOME_CLEARED;
                  end
                  FUNC_QUERY: begin
                     if (count_ff == '0) begin
                        res_outcome_in = OUTCOME_EMPTY;
                     end else begin
                        scan_in       = '0;
                        best_valid_in = 1'b0;
                        state_in      = ST_SCAN;
                     end
                  end
                  default: begin
                     // unused code: no change, report the current count
                  end
               endcase
            end
         end
         ST_SCAN: begin
            issue   = 1'b1;
            scan_in = scan_ff + IDX_W'(1);
            if (scan_ff == last_idx) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            if (!v1_ff && !v2_ff && !v3_ff) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (rsp_free) begin
               rsp_valid_in   = 1'b1;
               rsp_index_in   = INDEX_W'(res_index_ff);
               rsp_outcome_in = res_outcome_ff;
               rsp_dist_in    = res_dist_ff;
               rsp_count_in   = COUNT_W'(res_count_ff);
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // keep the first point at the least distance: strict compare in index order
      if (v3_ff && (!best_valid_ff || dist_ff < res_dist_ff)) begin
         best_valid_in = 1'b1;
         res_dist_in   = dist_ff;
         res_index_in  = idx3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         dims_ff       <= DIMS_RESET;
         rsp_valid_ff  <= 1'b0;
         best_valid_ff <= 1'b0;
         v1_ff         <= 1'b0;
         v2_ff         <= 1'b0;
         v3_ff         <= 1'b0;
      end else begin
         count_ff      <= count_in;
         rsp_valid_ff  <= rsp_valid_in;
         best_valid_ff <= best_valid_in;
         v1_ff         <= issue;
         v2_ff         <= v1_ff;
         v3_ff         <= v2_ff;
         if (csr_wr_en) begin
            dims_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      scan_ff        <= scan_in;
      res_index_ff   <= res_index_in;
      res_outcome_ff <= res_outcome_in;
      res_dist_ff    <= res_dist_in;
      res_count_ff   <= res_count_in;
      q_ff           <= q_in;
      rsp_index_ff   <= rsp_index_in;
      rsp_outcome_ff <= rsp_outcome_in;
      rsp_dist_ff    <= rsp_dist_in;
      rsp_count_ff   <= rsp_count_in;
      idx1_ff        <= scan_ff;
      idx2_ff        <= idx1_ff;
      idx3_ff        <= idx2_ff;
      sq_ff          <= sq_in;
      dist_ff        <= sum_in;
   end

   // point memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[count_ff[IDX_W-1:0]] <= mem_wr_data;
      end
      if (issue) begin
         rd_data_ff <= mem[scan_ff];
      end
   end

endmodule
